>>> design/isp_pkg.sv
package isp_pkg;

   localparam int VERT_BITS = 32;

   // Result queue sizing.
   localparam int RSP_DEPTH    = 4;
   localparam int RSP_PTR_BITS = 2;
   localparam int RSP_CNT_BITS = 3;

   // List positions at which a group of an adjacency mode is complete.
   localparam logic [2:0] POS_LINE_ADJ_LAST = 3'd3;
   localparam logic [2:0] POS_TRI_ADJ_LAST  = 3'd5;

   // Register indexes of the control port.
   localparam logic REG_DRAW_TRIANGLES    = 1'b0;
   localparam logic REG_CONNECTIVITY_MODE = 1'b1;

   typedef enum logic [2:0] {
      MODE_LIST      = 3'd0,
      MODE_STRIP     = 3'd1,
      MODE_FAN       = 3'd2,
      MODE_ADJ       = 3'd3,
      MODE_STRIP_ADJ = 3'd4,
      MODE_LOOP      = 3'd5
   } conn_mode_type;

   typedef struct packed {
      logic [VERT_BITS-1:0] vert_a;
      logic [VERT_BITS-1:0] vert_b;
      logic [VERT_BITS-1:0] vert_c;
      logic                 is_triangle;
      logic                 mode_error;
      logic                 last_in_run;
   } result_type;

   // Up to two primitives produced by one request.
   typedef struct packed {
      logic       v0;
      logic       v1;
      result_type r0;
      result_type r1;
   } push_type;

endpackage

>>> design/index_stream_primitive_assembly.sv
// Index stream primitive assembly. Each request carries one vertex index,
// with tlast marking the last index of a list, and the block turns the list
// into line or triangle primitives as selected by the two control registers.
// One request is taken per clock while req_tready is high; a request
// produces zero, one or two responses, which are registered into a
// four-entry queue. req_tready stays high while that queue has room for
// two, so the input runs at one request per cycle as long as the output
// drains one response per cycle; only the closing line of a line loop
// adds a second response for one request. Writing either register
// restarts the current list. Indices are kept at INDEX_BITS and returned
// zero-extended.
module index_stream_primitive_assembly
   import isp_pkg::*;
#(
   parameter int INDEX_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] vertex_index
   input  logic        req_tlast,   // end_of_list

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // [31:0] vert_a, [63:32] vert_b, [95:64] vert_c
   output logic [1:0]  rsp_tuser,   // [0] is_triangle, [1] mode_error
   output logic        rsp_tlast,   // last_in_run

   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic       draw_tri_ff, draw_tri_in;
   logic [2:0] mode_ff, mode_in;
   logic       cfg_wr;
   logic       req_acc;
   logic       space_ok;
   push_type   asm_push;
   result_type rsp_data;

   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign req_tready = space_ok;
   assign req_acc    = req_tvalid && req_tready;

   always_comb begin
      draw_tri_in = draw_tri_ff;
      mode_in     = mode_ff;
      if (cfg_wr) begin
         case (csr_paddr[2])
            REG_DRAW_TRIANGLES:    draw_tri_in = csr_pwdata[0];
            REG_CONNECTIVITY_MODE: mode_in     = csr_pwdata[2:0];
            default:               draw_tri_in = draw_tri_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_DRAW_TRIANGLES:    csr_prdata = {31'd0, draw_tri_ff};
         REG_CONNECTIVITY_MODE: csr_prdata = {29'd0, mode_ff};
         default:               csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         draw_tri_ff <= 1'b1;
         mode_ff     <= MODE_LIST;
      end else begin
         draw_tri_ff <= draw_tri_in;
         mode_ff     <= mode_in;
      end
   end

   isp_assembler #(
      .INDEX_BITS (INDEX_BITS)
   ) u_assembler (
      .clock          (clock),
      .reset          (reset),
      .cfg_clear      (cfg_wr),
      .draw_triangles (draw_tri_ff),
      .conn_mode      (mode_ff),
      .in_valid       (req_acc),
      .vertex_index   (req_tdata),
      .end_of_list    (req_tlast),
      .push           (asm_push)
   );

   isp_result_fifo u_result_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (asm_push),
      .space_ok  (space_ok),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_data)
   );

   assign rsp_tdata = {rsp_data.vert_c, rsp_data.vert_b, rsp_data.vert_a};
   assign rsp_tuser = {rsp_data.mode_error, rsp_data.is_triangle};
   assign rsp_tlast = rsp_data.last_in_run;

   // A second primitive is only ever produced together with a first one.
   assert property (@(posedge clock) disable iff (reset)
      asm_push.v1 |-> asm_push.v0)
      else $error("second primitive pushed without a first one");

   // An unsupported mode gives exactly one response, marked last.
   assert property (@(posedge clock) disable iff (reset)
      (asm_push.v0 && asm_push.r0.mode_error) |->
         (!asm_push.v1 && asm_push.r0.last_in_run))
      else $error("mode error response is not a single last response");

   // A request that completes a primitive shows a response in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_acc && asm_push.v0) |=> rsp_tvalid)
      else $error("completed primitive not presented");

   // Lines carry no third vertex.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata[95:64] == 32'd0))
      else $error("line response with nonzero third vertex");

endmodule

>>> design/isp_assembler.sv
module isp_assembler
   import isp_pkg::*;
#(
   parameter int INDEX_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cfg_clear,
   input  logic                 draw_triangles,
   input  logic [2:0]           conn_mode,
   input  logic                 in_valid,
   input  logic [VERT_BITS-1:0] vertex_index,
   input  logic                 end_of_list,
   output push_type             push
);

   logic [2:0]            pos_ff, pos_in;
   logic [INDEX_BITS-1:0] first_ff, first_in;
   logic [INDEX_BITS-1:0] hist_ff [3];
   logic [INDEX_BITS-1:0] hist_in [3];
   logic                  parity_ff, parity_in;

   logic [INDEX_BITS-1:0] v;
   logic [INDEX_BITS-1:0] first_eff;
   logic                  mode_ok;
   logic                  shift;

   function automatic result_type prim(input logic [INDEX_BITS-1:0] a,
                                       input logic [INDEX_BITS-1:0] b,
                                       input logic [INDEX_BITS-1:0] c,
                                       input logic tri_flag,
                                       input logic err);
      result_type r;
      r.vert_a      = VERT_BITS'(a);
      r.vert_b      = VERT_BITS'(b);
      r.vert_c      = VERT_BITS'(c);
      r.is_triangle = tri_flag;
      r.mode_error  = err;
      r.last_in_run = 1'b0;
      return r;
   endfunction

   assign v = vertex_index[INDEX_BITS-1:0];

   always_comb begin
      if (draw_triangles) begin
         mode_ok = (conn_mode <= MODE_STRIP_ADJ);
      end else begin
         mode_ok = (conn_mode <= MODE_LOOP) && (conn_mode != MODE_FAN);
      end
   end

   // A loop of a single index closes on itself, so the first vertex is
   // taken from the request when the list is just starting.
   assign first_eff = (pos_ff == 3'd0) ? v : first_ff;

   always_comb begin
      push      = '0;
      pos_in    = pos_ff;
      first_in  = first_ff;
      parity_in = parity_ff;
      shift     = 1'b0;
      for (int i = 0; i < 3; i++) begin
         hist_in[i] = hist_ff[i];
      end

      if (in_valid) begin
         shift = 1'b1;
         if (!mode_ok) begin
            push.v0 = 1'b1;
            push.r0 = prim('0, '0, '0, draw_triangles, 1'b1);
            shift   = 1'b0;
         end else if (!draw_triangles) begin
            case (conn_mode)
               MODE_LIST: begin
                  if (pos_ff == 3'd1) begin
                     push.v0 = 1'b1;
                     push.r0 = prim(hist_ff[0], v, '0, 1'b0, 1'b0);
                  end
                  pos_in = (pos_ff == 3'd1) ? 3'd0 : 3'd1;
               end
               MODE_STRIP, MODE_LOOP: begin
                  if (pos_ff == 3'd0) begin
                     first_in = v;
                  end
                  pos_in = 3'd1;
                  if (pos_ff != 3'd0) begin
                     push.v0 = 1'b1;
                     push.r0 = prim(hist_ff[0], v, '0, 1'b0, 1'b0);
                     if (conn_mode == MODE_LOOP && end_of_list) begin
                        push.v1 = 1'b1;
                        push.r1 = prim(v, first_eff, '0, 1'b0, 1'b0);
                     end
                  end else if (conn_mode == MODE_LOOP && end_of_list) begin
                     push.v0 = 1'b1;
                     push.r0 = prim(v, first_eff, '0, 1'b0, 1'b0);
                  end
               end
               MODE_ADJ: begin
                  if (pos_ff == POS_LINE_ADJ_LAST) begin
                     push.v0 = 1'b1;
                     push.r0 = prim(hist_ff[1], hist_ff[0], '0, 1'b0, 1'b0);
                  end
                  pos_in = {1'b0, 2'(pos_ff[1:0] + 2'd1)};
               end
               MODE_STRIP_ADJ: begin
                  if (pos_ff >= 3'd3) begin
                     push.v0 = 1'b1;
                     push.r0 = prim(hist_ff[1], hist_ff[0], '0, 1'b0, 1'b0);
                  end
                  pos_in = (pos_ff >= 3'd3) ? 3'd3 : 3'(pos_ff + 3'd1);
               end
               default: begin
                  shift = 1'b0;
               end
            endcase
         end else begin
            case (conn_mode)
               MODE_LIST: begin
                  if (pos_ff == 3'd2) begin
                     push.v0 = 1'b1;
                     push.r0 = prim(hist_ff[1], hist_ff[0], v, 1'b1, 1'b0);
                  end
                  pos_in = (pos_ff >= 3'd2) ? 3'd0 : 3'(pos_ff + 3'd1);
               end
               MODE_STRIP: begin
                  if (pos_ff >= 3'd2) begin
                     push.v0 = 1'b1;
                     if (parity_ff) begin
                        push.r0 = prim(hist_ff[0], hist_ff[1], v, 1'b1, 1'b0);
                     end else begin
                        push.r0 = prim(hist_ff[1], hist_ff[0], v, 1'b1, 1'b0);
                     end
                     parity_in = ~parity_ff;
                  end
                  pos_in = (pos_ff >= 3'd2) ? 3'd2 : 3'(pos_ff + 3'd1);
               end
               MODE_FAN: begin
                  if (pos_ff == 3'd0) begin
                     first_in = v;
                  end
                  if (pos_ff >= 3'd2) begin
                     push.v0 = 1'b1;
                     push.r0 = prim(first_ff, hist_ff[0], v, 1'b1, 1'b0);
                  end
                  pos_in = (pos_ff >= 3'd2) ? 3'd2 : 3'(pos_ff + 3'd1);
               end
               MODE_ADJ: begin
                  // Only even positions carry triangle corners.
                  shift = ~pos_ff[0];
                  if (pos_ff == POS_TRI_ADJ_LAST) begin
                     push.v0 = 1'b1;
                     push.r0 = prim(hist_ff[2], hist_ff[1], hist_ff[0], 1'b1, 1'b0);
                  end
                  pos_in = (pos_ff >= POS_TRI_ADJ_LAST) ? 3'd0 : 3'(pos_ff + 3'd1);
               end
               MODE_STRIP_ADJ: begin
                  shift = ~pos_ff[0];
                  if (pos_ff >= POS_TRI_ADJ_LAST && pos_ff[0]) begin
                     push.v0 = 1'b1;
                     if (parity_ff) begin
                        push.r0 = prim(hist_ff[1], hist_ff[2], hist_ff[0], 1'b1, 1'b0);
                     end else begin
                        push.r0 = prim(hist_ff[2], hist_ff[1], hist_ff[0], 1'b1, 1'b0);
                     end
                     parity_in = ~parity_ff;
                  end
                  pos_in = (pos_ff >= POS_TRI_ADJ_LAST) ? 3'd4 : 3'(pos_ff + 3'd1);
               end
               default: begin
                  shift = 1'b0;
               end
            endcase
         end

         if (shift) begin
            hist_in[2] = hist_ff[1];
            hist_in[1] = hist_ff[0];
            hist_in[0] = v;
         end

         if (push.v1) begin
            push.r1.last_in_run = 1'b1;
         end else if (push.v0) begin
            push.r0.last_in_run = 1'b1;
         end

         if (end_of_list) begin
            pos_in    = 3'd0;
            first_in  = '0;
            parity_in = 1'b0;
            for (int i = 0; i < 3; i++) begin
               hist_in[i] = '0;
            end
         end
      end

      // A register write restarts the list.
      if (cfg_clear) begin
         pos_in    = 3'd0;
         first_in  = '0;
         parity_in = 1'b0;
         for (int i = 0; i < 3; i++) begin
            hist_in[i] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= 3'd0;
         first_ff  <= '0;
         parity_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            hist_ff[i] <= '0;
         end
      end else begin
         pos_ff    <= pos_in;
         first_ff  <= first_in;
         parity_ff <= parity_in;
         for (int i = 0; i < 3; i++) begin
            hist_ff[i] <= hist_in[i];
         end
      end
   end

endmodule

>>> design/isp_result_fifo.sv
module isp_result_fifo
   import isp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  push_type   push,
   output logic       space_ok,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   result_type              mem_ff [RSP_DEPTH];
   logic [RSP_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_BITS-1:0] count_ff, count_in;
   logic [RSP_PTR_BITS-1:0] wr_next;
   logic [1:0]              npush;
   logic                    pop;

   assign npush     = {1'b0, push.v0} + {1'b0, push.v1};
   assign pop       = out_valid && out_ready;
   assign wr_next   = RSP_PTR_BITS'(wr_ptr_ff + 1'b1);
   assign wr_ptr_in = RSP_PTR_BITS'(wr_ptr_ff + npush);
   assign rd_ptr_in = RSP_PTR_BITS'(rd_ptr_ff + pop);
   assign count_in  = RSP_CNT_BITS'(count_ff + npush - pop);

   // Room for the largest burst one request can cause.
   assign space_ok  = (count_ff <= RSP_CNT_BITS'(RSP_DEPTH - 2));
   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push.v0) begin
         mem_ff[wr_ptr_ff] <= push.r0;
      end
      if (push.v1) begin
         mem_ff[wr_next] <= push.r1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
